### rtl/rsltab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsltab_pkg
// Shared types and constants for the reassembly slot table and its cells.
// ----------------------------------------------------------------------------
package rsltab_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    localparam int OP_W       = 2;
    localparam int TIME_W     = 32;
    localparam int ID_W       = 32;
    localparam int IDX_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 3;
    localparam int EXP_W      = 4;
    localparam int IN_TDATA_W = 104;
    localparam int OUT_TDATA_W = 8;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [EXP_W-1:0]  EXP_MAX       = 4'd15;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FIND  = 2'd1,
        OP_FREE  = 2'd2,
        OP_AGE   = 2'd3
    } op_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_e_t;

    // Command broadcast to every cell at once.
    typedef enum logic [2:0] {
        CC_IDLE,
        CC_CHECK,
        CC_RELEASE,
        CC_ALLOC,
        CC_FIND
    } cell_cmd_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RELEASE,
        S_ALLOC,
        S_FIND,
        S_DONE
    } state_e_t;

    typedef struct packed {
        cell_cmd_e_t        kind;
        op_e_t              op;
        logic [TIME_W-1:0]  now_ms;
        logic [ID_W-1:0]    frame_id;
        logic [ID_W-1:0]    match_mask;
        logic [IDX_W-1:0]   slot_index;
        logic [TIME_W-1:0]  timeout_ms;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic rel_sel;
        logic alloc_sel;
        logic match;
    } cell_stat_t;

    // Priority chains: set once some lower cell has claimed the operation.
    typedef struct packed {
        logic pend;
        logic free;
    } cell_chain_t;

endpackage

### rtl/rsltab_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsltab_cell
// One reassembly slot: identifier, last-used time and age rank, with the
// local compare logic and its link in the lowest-index priority chains.
// ----------------------------------------------------------------------------
module rsltab_cell
    import rsltab_pkg::*;
#(
    parameter int RANK_W     = 3,
    parameter int CELL_INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_cmd_t         cmd,
    input  logic [RANK_W-1:0] bus_rank,
    input  cell_chain_t       chain_in,
    output cell_chain_t       chain_out,
    output cell_stat_t        stat,
    output logic [RANK_W-1:0] rank
);

    logic              valid_reg, valid_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [RANK_W-1:0] rank_reg, rank_next;

    logic              rel_sel;
    logic              alloc_sel;
    logic              match;
    logic              expired;
    logic              id_hit;
    logic              index_hit;
    logic [TIME_W-1:0] age;

    assign rel_sel   = pend_reg & ~chain_in.pend;
    assign alloc_sel = ~valid_reg & ~chain_in.free;
    assign match     = hit_reg & valid_reg & (rank_reg == bus_rank);

    assign chain_out.pend = chain_in.pend | pend_reg;
    assign chain_out.free = chain_in.free | ~valid_reg;

    // The age wraps with the millisecond counter.
    assign age       = cmd.now_ms - time_reg;
    assign expired   = valid_reg & (age > cmd.timeout_ms);
    assign id_hit    = valid_reg & (((id_reg ^ cmd.frame_id) & cmd.match_mask) == '0);
    assign index_hit = valid_reg & (32'(cmd.slot_index) == 32'(CELL_INDEX));

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        hit_next   = hit_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        rank_next  = rank_reg;
        case (cmd.kind)
            CC_CHECK:
            begin
                hit_next = id_hit;
                case (cmd.op)
                    OP_ALLOC, OP_AGE: pend_next = expired;
                    OP_FREE:          pend_next = index_hit;
                    default:          pend_next = 1'b0;
                endcase
            end
            CC_RELEASE:
            begin
                if (rel_sel)
                begin
                    valid_next = 1'b0;
                    pend_next  = 1'b0;
                end
                else if (valid_reg && rank_reg > bus_rank)
                begin
                    rank_next = rank_reg - 1'b1;
                end
            end
            CC_ALLOC:
            begin
                if (alloc_sel)
                begin
                    valid_next = 1'b1;
                    id_next    = cmd.frame_id;
                    time_next  = cmd.now_ms;
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            CC_FIND:
            begin
                if (match)
                begin
                    time_next = cmd.now_ms;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
        rank_reg <= rank_next;
    end

    assign stat.valid     = valid_reg;
    assign stat.hit       = hit_reg;
    assign stat.rel_sel   = rel_sel;
    assign stat.alloc_sel = alloc_sel;
    assign stat.match     = match;
    assign rank           = rank_reg;

endmodule

### rtl/reassembly_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reassembly_slot_table
// Reassembly slot table for fragmented CAN frames, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage: a request beat on the s_ channel carries the operation in s_tuser
// and the time, identifier, match mask and slot index in s_tdata. Each
// request gives exactly one result beat on the m_ channel: status in m_tuser,
// slot and expired count in m_tdata. The timeout register is written through
// cfg_we/cfg_wdata; the user must write it only while no request is in flight, as the block does not enforce this.
// Requests are handled one at a time by a small sequencer that drives all
// cells at once. Allocate checks all cells, releases the slots that the
// timeout sweep finds (one release per cycle, since each release renumbers
// the ranks of all cells) and then fills the lowest free slot; age-out does
// the same without the fill; free checks and releases the slot at slot_index;
// find steps a rank counter through the cells from the newest. The sequencer
// goes back to idle after the result is loaded, and only there takes the next request beat.
// Reset empties every slot and loads the timeout with 1000 ms. A result waits
// in the output register while m_tready is low; the next request is still
// accepted and worked on, and its result waits until the register drains.
// ----------------------------------------------------------------------------
module reassembly_slot_table
    import rsltab_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms [31:0], frame_id [63:32], match_mask [95:64], slot_index [98:96]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // operation [1:0]
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // result_slot [2:0], expired_count [6:3]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]    m_tuser,
    input  logic                   cfg_we,
    input  logic [TIME_W-1:0]      cfg_wdata
);

    localparam int RANK_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(SLOT_COUNT - 1);

    state_e_t            state_reg, state_next;
    op_e_t               op_reg, op_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [ID_W-1:0]     mask_reg, mask_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TIME_W-1:0]   timeout_reg;
    logic [EXP_W-1:0]    count_reg, count_next;
    logic [RANK_W-1:0]   search_reg, search_next;
    logic                freed_reg, freed_next;
    status_e_t           res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    cell_cmd_t           cmd;
    cell_cmd_e_t         cmd_kind;
    logic [RANK_W-1:0]   bus_rank;
    cell_chain_t         chain [0:SLOT_COUNT];
    cell_stat_t          stat [0:SLOT_COUNT-1];
    logic [RANK_W-1:0]   rank [0:SLOT_COUNT-1];

    logic                any_pend;
    logic                any_free;
    logic                any_hit;
    logic                any_match;
    logic [RANK_W-1:0]   rel_rank;
    logic [RANK_W-1:0]   alloc_idx;
    logic [RANK_W-1:0]   match_idx;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++)
        begin : g_cell
            rsltab_cell #(
                .RANK_W     (RANK_W),
                .CELL_INDEX (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .bus_rank  (bus_rank),
                .chain_in  (chain[g]),
                .chain_out (chain[g+1]),
                .stat      (stat[g]),
                .rank      (rank[g])
            );
        end
    endgenerate

    assign any_pend = chain[SLOT_COUNT].pend;
    assign any_free = chain[SLOT_COUNT].free;

    // Only one cell is selected at a time, so plain ORs collect its data.
    always_comb
    begin
        any_hit   = 1'b0;
        any_match = 1'b0;
        rel_rank  = '0;
        alloc_idx = '0;
        match_idx = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            any_hit   = any_hit | (stat[k].hit & stat[k].valid);
            any_match = any_match | stat[k].match;
            rel_rank  = rel_rank | (stat[k].rel_sel ? rank[k] : '0);
            alloc_idx = alloc_idx | (stat[k].alloc_sel ? RANK_W'(k) : '0);
            match_idx = match_idx | (stat[k].match ? RANK_W'(k) : '0);
        end
    end

    assign bus_rank = (state_reg == S_FIND) ? search_reg : rel_rank;

    assign cmd.kind       = cmd_kind;
    assign cmd.op         = op_reg;
    assign cmd.now_ms     = now_reg;
    assign cmd.frame_id   = id_reg;
    assign cmd.match_mask = mask_reg;
    assign cmd.slot_index = idx_reg;
    assign cmd.timeout_ms = timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            timeout_reg  <= TIMEOUT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        now_reg        <= now_next;
        id_reg         <= id_next;
        mask_reg       <= mask_next;
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        search_reg     <= search_next;
        freed_reg      <= freed_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        id_next         = id_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        search_next     = search_reg;
        freed_next      = freed_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        cmd_kind        = CC_IDLE;
        s_tready        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next    = op_e_t'(s_tuser);
                    now_next   = s_tdata[31:0];
                    id_next    = s_tdata[63:32];
                    mask_next  = s_tdata[95:64];
                    idx_next   = s_tdata[98:96];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd_kind    = CC_CHECK;
                count_next  = '0;
                search_next = '0;
                freed_next  = 1'b0;
                state_next  = (op_reg == OP_FIND) ? S_FIND : S_RELEASE;
            end
            S_RELEASE:
            begin
                if (any_pend)
                begin
                    cmd_kind   = CC_RELEASE;
                    freed_next = 1'b1;
                    if (op_reg != OP_FREE && count_reg != EXP_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (op_reg == OP_ALLOC)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    res_slot_next = '0;
                    if (op_reg == OP_FREE && !freed_reg)
                    begin
                        res_status_next = ST_NONE;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                    end
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                if (any_free)
                begin
                    cmd_kind        = CC_ALLOC;
                    res_status_next = ST_OK;
                    res_slot_next   = SLOT_W'(alloc_idx);
                end
                else
                begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                end
                state_next = S_DONE;
            end
            S_FIND:
            begin
                cmd_kind = CC_FIND;
                // Ranks of valid slots are distinct, so the first rank that
                // matches belongs to the newest matching slot.
                if (any_match)
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = SLOT_W'(match_idx);
                    state_next      = S_DONE;
                end
                else if (!any_hit || search_reg == LAST_RANK)
                begin
                    res_status_next = ST_NONE;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    search_next = search_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {1'b0, count_reg, res_slot_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/reassembly_slot_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reassembly_slot_table_checker
// Watches the request, result and timeout-write ports of the slot table. It
// keeps its own copy of the slots and the timeout, works out the result of
// every accepted request and compares each result beat against it in order.
// ----------------------------------------------------------------------------
module reassembly_slot_table_checker
    import rsltab_pkg::*;
#(
    parameter int SLOTS = SLOT_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]    m_tuser,
    input  logic                   cfg_we,
    input  logic [TIME_W-1:0]      cfg_wdata,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        status_e_t          status;
        logic [SLOT_W-1:0]  slot;
        logic [EXP_W-1:0]   expired;
    } slot_result_t;

    logic [TIME_W-1:0] timeout_copy;
    logic              slot_used  [SLOTS];
    logic [ID_W-1:0]   slot_ident [SLOTS];
    logic [TIME_W-1:0] slot_stamp [SLOTS];
    int unsigned       slot_rank  [SLOTS];
    slot_result_t      expected_results [$];
    int                fail_total;

    // Dropping a slot pulls every older slot one rank closer to the newest.
    function automatic void drop_slot(int s);
        for (int k = 0; k < SLOTS; k++) begin
            if (slot_used[k] && k != s && slot_rank[k] > slot_rank[s])
                slot_rank[k] = slot_rank[k] - 1;
        end
        slot_used[s] = 1'b0;
    endfunction

    function automatic int unsigned expire_idle_slots(logic [TIME_W-1:0] now);
        int unsigned n;
        n = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && (now - slot_stamp[s]) > timeout_copy) begin
                drop_slot(s);
                n++;
            end
        end
        return n;
    endfunction

    function automatic slot_result_t predict_slot_op(op_e_t op, logic [TIME_W-1:0] now,
                                                     logic [ID_W-1:0] id,
                                                     logic [ID_W-1:0] mask,
                                                     logic [IDX_W-1:0] idx);
        slot_result_t r;
        int unsigned  n;
        bit           hit;
        bit           placed;
        int           best;
        r.status = ST_OK;
        r.slot   = '0;
        n        = 0;
        hit      = 1'b0;
        placed   = 1'b0;
        best     = 0;
        case (op)
            OP_ALLOC: begin
                n = expire_idle_slots(now);
                r.status = ST_FULL;
                for (int s = 0; s < SLOTS; s++) begin
                    if (!placed && !slot_used[s]) begin
                        for (int k = 0; k < SLOTS; k++)
                            if (slot_used[k])
                                slot_rank[k] = slot_rank[k] + 1;
                        slot_used[s]  = 1'b1;
                        slot_ident[s] = id;
                        slot_stamp[s] = now;
                        slot_rank[s]  = 0;
                        r.slot   = SLOT_W'(s);
                        r.status = ST_OK;
                        placed   = 1'b1;
                    end
                end
            end
            OP_FIND: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_used[s] && ((slot_ident[s] & mask) == (id & mask))) begin
                        if (!hit || slot_rank[s] < slot_rank[best])
                            best = s;
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    slot_stamp[best] = now;
                    r.slot = SLOT_W'(best);
                end
                else begin
                    r.status = ST_NONE;
                end
            end
            OP_FREE: begin
                if (int'(idx) < SLOTS && slot_used[idx])
                    drop_slot(int'(idx));
                else
                    r.status = ST_NONE;
            end
            default: begin
                n = expire_idle_slots(now);
            end
        endcase
        r.expired = (n > 15) ? EXP_MAX : EXP_W'(n);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t want;
        if (!rst_n)
        begin
            timeout_copy = TIMEOUT_RESET;
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_used[s]  = 1'b0;
                slot_ident[s] = '0;
                slot_stamp[s] = '0;
                slot_rank[s]  = 0;
            end
            expected_results.delete();
            fail_total  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                timeout_copy = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_slot_op(op_e_t'(s_tuser),
                    s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[98:96]));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: status %0d slot %0d expired %0d",
                             $time, m_tuser, m_tdata[2:0], m_tdata[6:3]);
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fail_total++;
                    end
                    if (m_tdata[2:0] != want.slot)
                    begin
                        $display("%0t: result_slot expected %0d actual %0d",
                                 $time, want.slot, m_tdata[2:0]);
                        fail_total++;
                    end
                    if (m_tdata[6:3] != want.expired)
                    begin
                        $display("%0t: expired_count expected %0d actual %0d",
                                 $time, want.expired, m_tdata[6:3]);
                        fail_total++;
                    end
                end
            end
            mismatches  <= fail_total;
            outstanding <= expected_results.size();
        end
    end

endmodule

### tb/reassembly_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reassembly_slot_table_tb
// Drives the slot table with a directed run of allocate, find, free and
// age-out requests, then random traffic under several timeout settings with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module reassembly_slot_table_tb;
    import rsltab_pkg::*;

    localparam int PHASE_ITEMS = 275;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]        s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [TIME_W-1:0]      cfg_wdata = '0;

    int                     mismatches;
    int                     outstanding;

    bit                     calm = 1'b0;
    int                     stall_left = 0;
    logic [TIME_W-1:0]      clock_ms;
    logic [TIME_W-1:0]      timeout_shadow = TIMEOUT_RESET;
    logic [ID_W-1:0]        recent_ids [8];
    int                     recent_wr = 0;

    always #2 clk = ~clk;

    reassembly_slot_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    reassembly_slot_table_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    // Result side: random stalls, none during calm stretches.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            m_tready   <= 1'b0;
            stall_left = idle_cycles();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_req(op_e_t op, logic [TIME_W-1:0] now, logic [ID_W-1:0] id,
                            logic [ID_W-1:0] mask, logic [IDX_W-1:0] idx);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W - IDX_W - 3 * 32){1'b0}}, idx, mask, id, now};
        do @(posedge clk); while (!s_tready);
    endtask

    // Waits until every result is back and the sequencer has gone idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_timeout(logic [TIME_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        timeout_shadow = value;
    endtask

    // Moves the clock mostly in steps small against the timeout, sometimes
    // right to the expiry edge, sometimes far away or slightly backwards.
    task automatic advance_clock();
        int                r;
        logic [TIME_W-1:0] span;
        r    = $urandom_range(0, 99);
        span = timeout_shadow >> 2;
        if (span == 0)
            span = 3;
        if (r < 10)
            clock_ms = clock_ms;
        else if (r < 70)
            clock_ms = clock_ms + $urandom_range(0, span);
        else if (r < 85)
            clock_ms = clock_ms + timeout_shadow + $urandom_range(0, 1);
        else if (r < 95)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms - $urandom_range(1, 64);
    endtask

    task automatic random_req();
        int               r;
        op_e_t            op;
        logic [ID_W-1:0]  id;
        logic [ID_W-1:0]  mask;
        logic [IDX_W-1:0] idx;
        advance_clock();
        r    = $urandom_range(0, 99);
        id   = $urandom;
        mask = $urandom;
        idx  = $urandom_range(0, 7);
        if (r < 35)
        begin
            op = OP_ALLOC;
            r  = $urandom_range(0, 99);
            if (r >= 75)
                id = recent_ids[$urandom_range(0, 7)] ^ (32'h1 << $urandom_range(0, 3));
            else if (r >= 50)
                id = recent_ids[$urandom_range(0, 7)];
            recent_ids[recent_wr] = id;
            recent_wr = (recent_wr + 1) % 8;
        end
        else if (r < 70)
        begin
            op = OP_FIND;
            if ($urandom_range(0, 99) < 75)
                id = recent_ids[$urandom_range(0, 7)];
            r = $urandom_range(0, 99);
            if (r < 40)
                mask = '1;
            else if (r < 60)
                mask = '0;
            else if (r >= 80)
                mask = ~(32'h1 << $urandom_range(0, 31));
        end
        else if (r < 85)
        begin
            op = OP_FREE;
        end
        else
        begin
            op = OP_AGE;
        end
        send_req(op, clock_ms, id, mask, idx);
    endtask

    initial
    begin
        logic [ID_W-1:0]   fill_ids [8];
        logic [TIME_W-1:0] phase_timeouts [6];
        fill_ids       = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00A5, 32'h0000_00A4,
                           32'h0000_00A5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678};
        phase_timeouts = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd50, 32'd20000, 32'd0};
        for (int i = 0; i < 8; i++)
            recent_ids[i] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset timeout of 1000 ms.
        send_req(OP_AGE, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        send_req(OP_FREE, 32'd0, 32'd0, 32'd0, 3'd7);
        send_req(OP_FIND, 32'd0, 32'd0, 32'd0, 3'd0);
        // Fill the table with times that wrap through zero.
        for (int i = 0; i < 8; i++)
            send_req(OP_ALLOC, 32'hFFFF_FF00 + 32'h40 * i, fill_ids[i], 32'd0, 3'd0);
        send_req(OP_ALLOC, 32'h0000_0100, 32'hCAFE_0001, 32'd0, 3'd0);
        // Duplicate and masked identifiers pick the newest match.
        send_req(OP_FIND, 32'h0000_0110, 32'h0000_00A5, 32'hFFFF_FFFF, 3'd0);
        send_req(OP_FIND, 32'h0000_0120, 32'h0000_00A4, 32'hFFFF_FFFE, 3'd0);
        send_req(OP_FIND, 32'h0000_0130, 32'h0000_DEAD, 32'h0000_0000, 3'd0);
        send_req(OP_FIND, 32'h0000_0140, 32'h0000_DEAD, 32'hFFFF_FFFF, 3'd0);
        send_req(OP_FREE, 32'h0000_0150, 32'd0, 32'd0, 3'd3);
        send_req(OP_FREE, 32'h0000_0160, 32'd0, 32'd0, 3'd3);
        send_req(OP_ALLOC, 32'h0000_0200, 32'h0000_5A5A, 32'd0, 3'd0);
        // Every slot is far past the timeout here.
        send_req(OP_AGE, 32'h8000_0000, 32'd0, 32'd0, 3'd0);
        send_req(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);

        clock_ms = 32'hFFFF_F000;
        for (int p = 0; p < 6; p++)
        begin
            write_timeout((p == 5) ? TIME_W'($urandom) : phase_timeouts[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 100 == 0)
                    calm <= ($urandom_range(0, 3) == 0);
                random_req();
            end
        end

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/rsltab_pkg.sv
rtl/rsltab_cell.sv
rtl/reassembly_slot_table.sv
tb/reassembly_slot_table_checker.sv
tb/reassembly_slot_table_tb.sv
